// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define CMX_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds while out of reset.
`define CMX_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/cmx_pkg.sv =====
package cmx_pkg;

    // Field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int ACC_BITS     = 32;
    localparam int N_BITS       = 24;
    localparam int FADE_FRAC    = 24;
    localparam int FADE_BITS    = FADE_FRAC + 1;
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 3;

    // Lane values after pan, fade and trim stay within one bit above the sample
    localparam int LANE_BITS = SAMPLE_BITS + 1;

    // Shared multiplier operand width
    localparam int MUL_BITS = 26;

    // Fixed-point scales
    localparam int PAN_DEN   = 16256;
    localparam int PAN_FRAC  = 15;
    localparam int TRIM_FRAC = 16;
    localparam int TRIM_ONE  = 256;
    localparam int GAIN_ONE  = 32768;

    // Reciprocals for the constant divisions by 127 and by 255
    localparam int     RECIP_127_SH = 29;
    localparam longint RECIP_127    = 4227331;
    localparam int     RECIP_255_SH = 32;
    localparam longint RECIP_255    = 16843010;

    localparam logic [FADE_BITS-1:0] FADE_ONE = FADE_BITS'(1) << FADE_FRAC;

    // Opcodes
    typedef enum logic {
        OP_MIX  = 1'b0,
        OP_FADE = 1'b1
    } t_opcode;

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CHAN_TRIM  = 3'd0,
        CFG_SONG_TRIM  = 3'd1,
        CFG_CHAN_PAN   = 3'd2,
        CFG_SONG_PAN   = 3'd3,
        CFG_SRC_STEREO = 3'd4,
        CFG_OUT_STEREO = 3'd5
    } t_cfg_idx;

    // Scaling applied after the multiply
    typedef enum logic [2:0] {
        SH_NONE,
        SH_Q15,
        SH_Q16,
        SH_Q24,
        SH_R127,
        SH_R255
    } t_shift;

    // Destination register of a multiply
    typedef enum logic [2:0] {
        TAG_P,
        TAG_G,
        TAG_T,
        TAG_L,
        TAG_R
    } t_tag;

    typedef struct packed {
        logic                        issue;
        logic signed [MUL_BITS-1:0]  a;
        logic signed [MUL_BITS-1:0]  b;
        t_shift                      sh;
        t_tag                        tag;
    } t_mul_op;

    typedef struct packed {
        logic                        valid;
        t_tag                        tag;
        logic signed [MUL_BITS-1:0]  res;
    } t_mul_res;

    typedef struct packed {
        logic                          opcode;
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
        logic signed [ACC_BITS-1:0]    acc_left;
        logic signed [ACC_BITS-1:0]    acc_right;
        logic [N_BITS-1:0]             fade_frames;
    } t_in_word;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] mix_left;
        logic signed [ACC_BITS-1:0] mix_right;
        logic                       finished;
    } t_out_word;

endpackage

// ===== hw/rtl/cmx_mul.sv =====
// Shared signed multiplier: product stage, then round and scale stage.
module cmx_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmx_pkg::t_mul_op  i_op,
    output cmx_pkg::t_mul_res o_res
);

    localparam int PB = 2 * cmx_pkg::MUL_BITS;

    localparam logic signed [PB-1:0] RND_Q15 = PB'(1) << (cmx_pkg::PAN_FRAC - 1);
    localparam logic signed [PB-1:0] RND_Q16 = PB'(1) << (cmx_pkg::TRIM_FRAC - 1);
    localparam logic signed [PB-1:0] RND_Q24 = PB'(1) << (cmx_pkg::FADE_FRAC - 1);

    logic                              r_v1;
    logic                              r_v2;
    logic signed [PB-1:0]              r_prod;
    cmx_pkg::t_shift                   r_sh;
    cmx_pkg::t_tag                     r_tag1;
    cmx_pkg::t_tag                     r_tag2;
    logic signed [cmx_pkg::MUL_BITS-1:0] r_res;
    logic signed [PB-1:0]              w_shr;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_op.issue;
            r_v2 <= r_v1;
        end
    end

    // Multiply, then round and scale
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_op.a) * $signed(i_op.b);
        r_sh   <= i_op.sh;
        r_tag1 <= i_op.tag;
        r_tag2 <= r_tag1;
        r_res  <= w_shr[cmx_pkg::MUL_BITS-1:0];
    end

    // Round half up where a fraction is dropped; reciprocal forms floor
    always_comb begin
        unique case (r_sh)
            cmx_pkg::SH_NONE: w_shr = r_prod;
            cmx_pkg::SH_Q15:  w_shr = (r_prod + RND_Q15) >>> cmx_pkg::PAN_FRAC;
            cmx_pkg::SH_Q16:  w_shr = (r_prod + RND_Q16) >>> cmx_pkg::TRIM_FRAC;
            cmx_pkg::SH_Q24:  w_shr = (r_prod + RND_Q24) >>> cmx_pkg::FADE_FRAC;
            cmx_pkg::SH_R127: w_shr = r_prod >>> cmx_pkg::RECIP_127_SH;
            cmx_pkg::SH_R255: w_shr = r_prod >>> cmx_pkg::RECIP_255_SH;
            default:          w_shr = r_prod;
        endcase
    end

    assign o_res.valid = r_v2;
    assign o_res.tag   = r_tag2;
    assign o_res.res   = r_res;

endmodule

// ===== hw/rtl/cmx_div.sv =====
// Restoring divider: full-scale fade level over the frame count, one bit a cycle.
module cmx_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cmx_pkg::N_BITS-1:0]    i_den,
    output logic                          o_fin,
    output logic [cmx_pkg::FADE_BITS-1:0] o_quo
);

    localparam int QB = cmx_pkg::FADE_BITS;
    localparam int CB = $clog2(QB);

    logic                          r_busy;
    logic                          r_fin;
    logic [CB-1:0]                 r_cnt;
    logic [cmx_pkg::N_BITS-1:0]    r_den;
    logic [QB-1:0]                 r_num;
    logic [QB-1:0]                 r_rem;
    logic [QB-1:0]                 r_quo;
    logic [QB-1:0]                 w_den_ext;
    logic [QB-1:0]                 w_rem_sh;
    logic                          w_ge;

    assign w_den_ext = {{(QB - cmx_pkg::N_BITS){1'b0}}, r_den};
    assign w_rem_sh  = {r_rem[QB-2:0], r_num[QB-1]};
    assign w_ge      = (w_rem_sh >= w_den_ext);

    // Count the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(QB - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit, subtract when the divisor fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_num <= cmx_pkg::FADE_ONE;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rem_sh - w_den_ext) : w_rem_sh;
            r_quo <= {r_quo[QB-2:0], w_ge};
            r_num <= r_num << 1;
        end
    end

    assign o_fin = r_fin;
    assign o_quo = r_quo;

endmodule

// ===== hw/rtl/channel_pan_fade_trim_mixer_unit.sv =====
// Mix word: accepted, then run through the issue slots of the shared multiplier schedule; the
// result is registered once the output is free, and no new word is taken until then.
// Fade start: the divider computes the ramp step, then the result is registered likewise.
// Finished channel or ignored fade start: goes straight to the output register.
// Synchronous active-low reset: registers to defaults, fade idle, channel not finished.
`include "assert_macros.svh"

module channel_pan_fade_trim_mixer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  cmx_pkg::t_in_word                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cmx_pkg::t_out_word               o_out,
    input  logic                             i_cfg_we,
    input  logic [cmx_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [cmx_pkg::CFG_BITS-1:0]     i_cfg_data
);

    localparam int MB = cmx_pkg::MUL_BITS;
    localparam int SB = cmx_pkg::SAMPLE_BITS;
    localparam int LB = cmx_pkg::LANE_BITS;
    localparam int AB = cmx_pkg::ACC_BITS;
    localparam int FB = cmx_pkg::FADE_BITS;

    // Multiply issue slots; a result is committed after the multiplier's product and scale registers
    localparam logic [3:0] SLOT_P   = 4'd0;
    localparam logic [3:0] SLOT_G   = 4'd1;
    localparam logic [3:0] SLOT_T   = 4'd3;
    localparam logic [3:0] SLOT_LP  = 4'd4;
    localparam logic [3:0] SLOT_RP  = 4'd5;
    localparam logic [3:0] SLOT_LF  = 4'd7;
    localparam logic [3:0] SLOT_RF  = 4'd8;
    localparam logic [3:0] SLOT_LT  = 4'd10;
    localparam logic [3:0] SLOT_RT  = 4'd11;
    localparam logic [3:0] MIX_LAST = 4'd14;

    localparam logic signed [17:0] PAN_MAX = 18'(cmx_pkg::PAN_DEN);
    localparam logic signed [17:0] PAN_MIN = -18'(cmx_pkg::PAN_DEN);
    localparam logic [8:0]  TRIM_ONE  = 9'(cmx_pkg::TRIM_ONE);
    localparam logic signed [MB-1:0] M127 = MB'(cmx_pkg::RECIP_127);
    localparam logic signed [MB-1:0] M255 = MB'(cmx_pkg::RECIP_255);
    localparam logic signed [MB-1:0] GAIN_ONE = MB'(cmx_pkg::GAIN_ONE);
    localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
    localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_DIV,
        S_FIN
    } t_state;

    t_state                   r_state;
    logic [3:0]               r_cnt;
    logic                     r_mix;
    logic [FB-1:0]            r_fade;
    logic [FB-1:0]            r_step;
    logic                     r_done;
    logic                     r_out_valid;
    cmx_pkg::t_out_word       r_out;
    cmx_pkg::t_in_word        r_in;

    logic [7:0]               r_chan_trim;
    logic [8:0]               r_song_trim;
    logic [7:0]               r_chan_pan;
    logic [8:0]               r_song_pan;
    logic                     r_src_stereo;
    logic                     r_out_stereo;

    logic [15:0]              r_p;
    logic [15:0]              r_g;
    logic [16:0]              r_t;
    logic signed [LB-1:0]     r_l;
    logic signed [LB-1:0]     r_r;

    cmx_pkg::t_mul_op         w_op;
    cmx_pkg::t_mul_res        w_mres;
    logic                     w_div_start;
    logic                     w_div_fin;
    logic [FB-1:0]            w_quo;
    logic [cmx_pkg::N_BITS-1:0] w_den;

    logic                     w_accept;
    logic                     w_fade_arm;
    logic                     w_slot_free;
    logic signed [17:0]       w_cp_off;
    logic signed [17:0]       w_sp;
    logic signed [17:0]       w_num;
    logic signed [17:0]       w_num_c;
    logic signed [17:0]       w_mag;
    logic [13:0]              w_d;
    logic [8:0]               w_st;
    logic                     w_pan_en;
    logic signed [MB-1:0]     w_gain_l;
    logic signed [MB-1:0]     w_gain_r;
    logic signed [MB-1:0]     w_fade_f;
    logic signed [FB:0]       w_fade_dec;
    logic                     w_fade_tick;
    logic                     w_fade_end;
    logic signed [AB:0]       w_sum_l;
    logic signed [AB:0]       w_sum_r;
    logic signed [AB-1:0]     w_sat_l;
    logic signed [AB-1:0]     w_sat_r;
    cmx_pkg::t_out_word       w_out;

    function automatic cmx_pkg::t_mul_op mk_op(
        input logic signed [MB-1:0] a,
        input logic signed [MB-1:0] b,
        input cmx_pkg::t_shift      sh,
        input cmx_pkg::t_tag        tag
    );
        cmx_pkg::t_mul_op op;
        op.issue = 1'b1;
        op.a     = a;
        op.b     = b;
        op.sh    = sh;
        op.tag   = tag;
        return op;
    endfunction

    function automatic logic signed [MB-1:0] lane_ext(input logic signed [LB-1:0] v);
        return {{(MB-LB){v[LB-1]}}, v};
    endfunction

    function automatic logic signed [AB-1:0] sat_acc(input logic signed [AB:0] s);
        if (s[AB] != s[AB-1]) begin
            return s[AB] ? ACC_MIN : ACC_MAX;
        end
        return s[AB-1:0];
    endfunction

    // Handshake
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_fade_arm  = !r_done && (r_fade == '0);
    assign w_div_start = w_accept && (i_in.opcode == cmx_pkg::OP_FADE) && w_fade_arm;
    assign w_den       = (i_in.fade_frames == '0) ? cmx_pkg::N_BITS'(1) : i_in.fade_frames;

    // Pan numerator, clamped, and the dividend input for the away-side gain
    assign w_cp_off = $signed({10'd0, r_chan_pan}) - 18'sd128;
    assign w_sp     = {{9{r_song_pan[8]}}, r_song_pan};
    assign w_num    = (w_cp_off <<< 7) + (w_sp <<< 7) - w_sp;
    assign w_num_c  = (w_num > PAN_MAX) ? PAN_MAX : ((w_num < PAN_MIN) ? PAN_MIN : w_num);
    assign w_mag    = (w_num_c < 0) ? -w_num_c : w_num_c;
    assign w_d      = 14'(PAN_MAX - w_mag);

    // Lane gains; unity gain leaves a lane exact
    assign w_pan_en = r_out_stereo && !r_src_stereo;
    assign w_gain_l = (w_pan_en && (w_num_c > 0)) ? $signed({{(MB-16){1'b0}}, r_g}) : GAIN_ONE;
    assign w_gain_r = (w_pan_en && (w_num_c < 0)) ? $signed({{(MB-16){1'b0}}, r_g}) : GAIN_ONE;
    assign w_fade_f = (r_fade != '0) ? $signed({{(MB-FB){1'b0}}, r_fade})
                                     : $signed({{(MB-FB){1'b0}}, cmx_pkg::FADE_ONE});
    assign w_st     = (r_song_trim > TRIM_ONE) ? TRIM_ONE : r_song_trim;

    // Issue the multiply schedule
    always_comb begin
        w_op = '0;
        if (r_state == S_MIX) begin
            unique case (r_cnt)
                SLOT_P: w_op = mk_op($signed({{(MB-8){1'b0}}, r_chan_trim}),
                                     $signed({{(MB-9){1'b0}}, w_st}),
                                     cmx_pkg::SH_NONE, cmx_pkg::TAG_P);
                SLOT_G: w_op = mk_op($signed({{(MB-22){1'b0}}, w_d, 8'h3F}), M127,
                                     cmx_pkg::SH_R127, cmx_pkg::TAG_G);
                SLOT_T: w_op = mk_op($signed({{(MB-24){1'b0}}, r_p, 8'h7F}), M255,
                                     cmx_pkg::SH_R255, cmx_pkg::TAG_T);
                SLOT_LP: w_op = mk_op({{(MB-SB){r_in.sample_left[SB-1]}}, r_in.sample_left},
                                      w_gain_l, cmx_pkg::SH_Q15, cmx_pkg::TAG_L);
                SLOT_RP: w_op = r_src_stereo
                    ? mk_op({{(MB-SB){r_in.sample_right[SB-1]}}, r_in.sample_right},
                            w_gain_r, cmx_pkg::SH_Q15, cmx_pkg::TAG_R)
                    : mk_op({{(MB-SB){r_in.sample_left[SB-1]}}, r_in.sample_left},
                            w_gain_r, cmx_pkg::SH_Q15, cmx_pkg::TAG_R);
                SLOT_LF: w_op = mk_op(lane_ext(r_l), w_fade_f, cmx_pkg::SH_Q24, cmx_pkg::TAG_L);
                SLOT_RF: w_op = mk_op(lane_ext(r_r), w_fade_f, cmx_pkg::SH_Q24, cmx_pkg::TAG_R);
                SLOT_LT: w_op = mk_op(lane_ext(r_l), $signed({{(MB-17){1'b0}}, r_t}),
                                      cmx_pkg::SH_Q16, cmx_pkg::TAG_L);
                SLOT_RT: w_op = mk_op(lane_ext(r_r), $signed({{(MB-17){1'b0}}, r_t}),
                                      cmx_pkg::SH_Q16, cmx_pkg::TAG_R);
                default: w_op = '0;
            endcase
        end
    end

    cmx_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_res   (w_mres)
    );

    cmx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_den),
        .o_fin   (w_div_fin),
        .o_quo   (w_quo)
    );

    // Commit multiply results to their destination
    always_ff @(posedge i_clk) begin
        if (w_mres.valid) begin
            unique case (w_mres.tag)
                cmx_pkg::TAG_P: r_p <= w_mres.res[15:0];
                cmx_pkg::TAG_G: r_g <= w_mres.res[15:0];
                cmx_pkg::TAG_T: r_t <= w_mres.res[16:0];
                cmx_pkg::TAG_L: r_l <= w_mres.res[LB-1:0];
                cmx_pkg::TAG_R: r_r <= w_mres.res[LB-1:0];
                default: ;
            endcase
        end
    end

    // Saturating sums and the fade step
    assign w_sum_l    = {r_in.acc_left[AB-1], r_in.acc_left}
                      + {{(AB+1-LB){r_l[LB-1]}}, r_l};
    assign w_sum_r    = {r_in.acc_right[AB-1], r_in.acc_right}
                      + {{(AB+1-LB){r_r[LB-1]}}, r_r};
    assign w_sat_l    = sat_acc(w_sum_l);
    assign w_sat_r    = sat_acc(w_sum_r);
    assign w_fade_dec = $signed({1'b0, r_fade}) - $signed({1'b0, r_step});
    assign w_fade_tick = r_mix && (r_fade != '0);
    assign w_fade_end  = (w_fade_dec <= 0);

    assign w_out.mix_left  = r_mix ? w_sat_l : r_in.acc_left;
    assign w_out.mix_right = (r_mix && r_out_stereo) ? w_sat_r : r_in.acc_right;
    assign w_out.finished  = r_done || (w_fade_tick && w_fade_end);

    // Sequencer, fade state, output register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_mix        <= 1'b0;
            r_fade       <= '0;
            r_step       <= '0;
            r_done       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_chan_trim  <= 8'd255;
            r_song_trim  <= 9'd256;
            r_chan_pan   <= 8'd128;
            r_song_pan   <= 9'd0;
            r_src_stereo <= 1'b0;
            r_out_stereo <= 1'b1;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in  <= i_in;
                        r_cnt <= '0;
                        if (i_in.opcode == cmx_pkg::OP_FADE) begin
                            r_mix   <= 1'b0;
                            r_state <= w_fade_arm ? S_DIV : S_FIN;
                        end else begin
                            r_mix   <= !r_done;
                            r_state <= r_done ? S_FIN : S_MIX;
                        end
                    end
                end
                S_MIX: begin
                    if (r_cnt == MIX_LAST) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DIV: begin
                    if (w_div_fin) begin
                        r_fade  <= cmx_pkg::FADE_ONE;
                        r_step  <= w_quo;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= w_out;
                        if (w_fade_tick) begin
                            r_fade <= w_fade_end ? '0 : w_fade_dec[FB-1:0];
                            r_done <= w_fade_end;
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cmx_pkg::CFG_CHAN_TRIM:  r_chan_trim  <= i_cfg_data[7:0];
                    cmx_pkg::CFG_SONG_TRIM:  r_song_trim  <= i_cfg_data[8:0];
                    cmx_pkg::CFG_CHAN_PAN:   r_chan_pan   <= i_cfg_data[7:0];
                    cmx_pkg::CFG_SONG_PAN:   r_song_pan   <= i_cfg_data[8:0];
                    cmx_pkg::CFG_SRC_STEREO: r_src_stereo <= i_cfg_data[0];
                    cmx_pkg::CFG_OUT_STEREO: r_out_stereo <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `CMX_ASSERT(a_mul_in_mix, i_clk, i_rst_n, w_mres.valid |-> (r_state == S_MIX), "multiply result outside mix schedule")
    `CMX_ASSERT(a_div_in_div, i_clk, i_rst_n, w_div_fin |-> (r_state == S_DIV), "divider finished outside fade start")
    `CMX_ASSERT(a_done_silent, i_clk, i_rst_n, r_done |-> (r_fade == '0), "finished channel with fade level left")
    `CMX_NEVER(a_fade_range, i_clk, i_rst_n, r_fade > cmx_pkg::FADE_ONE, "fade level above full scale")

endmodule
